/* design/hbd_pkg.sv */
// Package with the item, result, tree node and command types of the Huffman tree decoder.
`timescale 1ns / 1ps

package hbd_pkg;

    localparam int IDX_W        = 9;
    localparam int SYM_W        = 8;
    localparam int CMD_W        = 2;
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_CNT_W    = $clog2(BITS_PER_BYTE + 1);
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_INDEX_W  = 1;

    // Item command codes
    localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DECODE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GRAY_MODE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROOT_INDEX = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [IDX_W-1:0] node_index;
        logic [IDX_W-1:0] left_child;
        logic [IDX_W-1:0] right_child;
        logic             node_is_leaf;
        logic [SYM_W-1:0] leaf_symbol;
        logic [SYM_W-1:0] code_byte;
    } hbd_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] pixel_byte;
        logic             last_of_run;
    } hbd_result_t;

    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [SYM_W-1:0] symbol;
    } hbd_node_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // write one tree node
        logic restart;    // walk position back to the root
        logic begin_byte; // capture code bits, read the current node
        logic take_bit;   // follow one code bit, read the child node
        logic advance;    // child was no leaf: it becomes the walk position
        logic leaf_hit;   // child was a leaf: queue its symbol, read the root
        logic emit_copy;  // send a further copy of the queued symbol
        logic finish;     // send the queued symbol as the last of the run
    } hbd_cmd_t;

    typedef struct packed {
        logic node_leaf;  // leaf flag of the node in the read register
    } hbd_stat_t;

endpackage

/* design/huffman_tree_bit_decoder.sv */
// Top level of the Huffman tree decoder: configuration registers, controller and datapath.
`timescale 1ns / 1ps
// A decode item keeps the block busy while it walks the eight code bits and sends each symbol
// found; its last result is on the ports in the first cycle with busy low. Load and restart
// items cause no result. Throughput is set by the single read port of the node memory, one
// dependent node read per code bit or leaf, and by gray mode copies. The receiver cannot stall;
// results are not held. Reset clears the walk position, registers and controller, not the tree.
module huffman_tree_bit_decoder
    import hbd_pkg::*;
#(
    parameter int unsigned NODE_COUNT = 512
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  hbd_item_t              item,
    output hbd_result_t            result,
    output logic                   result_strobe,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Configuration registers. The user must see that they are written only while the block
    // is idle, so a change never lands in the middle of a walk; the block does not enforce it.
    logic             gray_mode_reg;
    logic [IDX_W-1:0] root_index_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_mode_reg  <= 1'b0;
            root_index_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRAY_MODE:  gray_mode_reg  <= cfg_data[0];
                REG_ROOT_INDEX: root_index_reg <= cfg_data[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    hbd_cmd_t  cmd;
    hbd_stat_t stat;

    // The controller walks one code bit per cycle while the node just read
    // is not a leaf. On a leaf it queues the symbol, reads the root node
    // and, in gray mode, then sends two copies of the queued symbol.
    hbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item_cmd  (item.cmd),
        .gray_mode (gray_mode_reg),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    // The datapath keeps one symbol queued, so that the last result of an
    // item can carry its flag once the whole code byte has been walked.
    hbd_dp #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .root_index    (root_index_reg),
        .cmd           (cmd),
        .stat          (stat),
        .result        (result),
        .result_strobe (result_strobe)
    );

    // A decode item that is taken keeps the block busy in the next cycle.
    a_decode_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.cmd == CMD_DECODE) |=> busy)
        else $error("decode item accepted but block not busy");

    // Results come only from a walk: an idle cycle is never followed by a result.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !result_strobe)
        else $error("result without a walk in progress");

    // The last result of an item is sent after the walk has ended.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last_of_run) |-> !busy)
        else $error("last result while still walking");

endmodule

/* design/hbd_ctrl.sv */
// Controller state machine that sequences the bit-by-bit tree walk.
`timescale 1ns / 1ps

module hbd_ctrl
    import hbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic [CMD_W-1:0] item_cmd,
    input  logic      gray_mode,
    input  hbd_stat_t stat,
    output hbd_cmd_t  cmd,
    output logic      busy
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_STEP = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                 check_leaf_reg, check_leaf_next;
    logic                 rep_reg, rep_next;
    logic                 accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next      = state_reg;
        bit_cnt_next    = bit_cnt_reg;
        check_leaf_next = check_leaf_reg;
        rep_next        = rep_reg;
        cmd             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item_cmd)
                        CMD_LOAD:    cmd.load = 1'b1;
                        CMD_RESTART: cmd.restart = 1'b1;
                        CMD_DECODE:
                        begin
                            cmd.begin_byte  = 1'b1;
                            bit_cnt_next    = '0;
                            check_leaf_next = 1'b0;
                            state_next      = ST_STEP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_STEP:
            begin
                if (check_leaf_reg && stat.node_leaf)
                begin
                    cmd.leaf_hit    = 1'b1;
                    check_leaf_next = 1'b0;
                    if (gray_mode)
                    begin
                        rep_next   = 1'b1;
                        state_next = ST_EMIT;
                    end
                end
                else if (bit_cnt_reg == BIT_CNT_W'(BITS_PER_BYTE))
                begin
                    // If the node reached by the last bit was no leaf, the walk stays there.
                    cmd.finish  = 1'b1;
                    cmd.advance = check_leaf_reg;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.take_bit    = 1'b1;
                    cmd.advance     = check_leaf_reg;
                    check_leaf_next = 1'b1;
                    bit_cnt_next    = bit_cnt_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                cmd.emit_copy = 1'b1;
                rep_next      = 1'b0;
                if (!rep_reg)
                begin
                    state_next = ST_STEP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bit_cnt_reg    <= '0;
            check_leaf_reg <= 1'b0;
            rep_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bit_cnt_reg    <= bit_cnt_next;
            check_leaf_reg <= check_leaf_next;
            rep_reg        <= rep_next;
        end
    end

endmodule

/* design/hbd_dp.sv */
// Datapath with the tree node memory, walk position, code bit shifter and result register.
`timescale 1ns / 1ps

module hbd_dp
    import hbd_pkg::*;
#(
    parameter int unsigned NODE_COUNT = 512
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  hbd_item_t        item,
    input  logic [IDX_W-1:0] root_index,
    input  hbd_cmd_t         cmd,
    output hbd_stat_t        stat,
    output hbd_result_t      result,
    output logic             result_strobe
);

    localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    hbd_node_t        mem [NODE_COUNT];
    hbd_node_t        rd_data_reg;
    logic             rd_zero_reg;
    hbd_node_t        node;

    logic [IDX_W-1:0] walk_pos_reg, walk_pos_next;
    logic [IDX_W-1:0] next_idx_reg;
    logic [SYM_W-1:0] bits_reg;
    logic [SYM_W-1:0] pend_sym_reg;
    logic             pend_valid_reg, pend_valid_next;
    logic             res_valid_next;
    hbd_result_t      res_reg, res_next;

    logic [IDX_W-1:0] child;
    logic [IDX_W-1:0] rd_idx;
    logic             rd_en;
    logic             wr_en;
    hbd_node_t        wr_node;

    // A node beyond the table reads as all zero.
    assign node           = rd_zero_reg ? hbd_node_t'('0) : rd_data_reg;
    assign stat.node_leaf = node.leaf;
    assign child          = bits_reg[0] ? node.right : node.left;

    always_comb
    begin
        rd_en  = cmd.begin_byte || cmd.take_bit || cmd.leaf_hit;
        rd_idx = walk_pos_reg;
        if (cmd.take_bit)
        begin
            rd_idx = child;
        end
        else if (cmd.leaf_hit)
        begin
            rd_idx = root_index;
        end
    end

    assign wr_en = cmd.load && (32'(item.node_index) < NODE_COUNT);

    always_comb
    begin
        wr_node.left   = item.left_child;
        wr_node.right  = item.right_child;
        wr_node.leaf   = item.node_is_leaf;
        wr_node.symbol = item.leaf_symbol;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ADDR_W'(item.node_index)] <= wr_node;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[ADDR_W'(rd_idx)];
            rd_zero_reg <= !(32'(rd_idx) < NODE_COUNT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.begin_byte)
        begin
            bits_reg <= item.code_byte;
        end
        else if (cmd.take_bit)
        begin
            bits_reg <= bits_reg >> 1;
        end
        if (cmd.take_bit)
        begin
            next_idx_reg <= child;
        end
        if (cmd.leaf_hit)
        begin
            pend_sym_reg <= node.symbol;
        end
        res_reg <= res_next;
    end

    always_comb
    begin
        walk_pos_next = walk_pos_reg;
        if (cmd.restart || cmd.leaf_hit)
        begin
            walk_pos_next = root_index;
        end
        else if (cmd.advance)
        begin
            walk_pos_next = next_idx_reg;
        end
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        if (cmd.leaf_hit)
        begin
            pend_valid_next = 1'b1;
        end
        else if (cmd.finish)
        begin
            pend_valid_next = 1'b0;
        end
        res_valid_next      = ((cmd.leaf_hit || cmd.finish) && pend_valid_reg) || cmd.emit_copy;
        res_next.pixel_byte = pend_sym_reg;
        res_next.last_of_run = cmd.finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_pos_reg   <= '0;
            pend_valid_reg <= 1'b0;
            result_strobe  <= 1'b0;
        end
        else
        begin
            walk_pos_reg   <= walk_pos_next;
            pend_valid_reg <= pend_valid_next;
            result_strobe  <= res_valid_next;
        end
    end

    assign result = res_reg;

endmodule
